>>> rtl/ips_patch_stream_applier_macros.svh
// Assertion macros used by the checker of the IPS patch stream applier.
`ifndef IPS_PATCH_STREAM_APPLIER_MACROS_SVH
`define IPS_PATCH_STREAM_APPLIER_MACROS_SVH

// same-cycle implication, off during reset
`define IPS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define IPS_ASSERT_HOLD(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked through reset
`define IPS_ASSERT_AFTER(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/ips_pkg.sv
// Shared types, constants and helpers of the IPS patch stream applier.
package ips_pkg;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 24;
   localparam int LEN_W    = 16;
   localparam int TLEN_W   = 25;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam int RSP_DEPTH_DEFAULT = 4;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MAGIC = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TRUNC = 2'd3;

   localparam logic [1:0] REG_CHECK_HEADER = 2'd0;
   localparam logic [1:0] REG_CHECK_END    = 2'd1;
   localparam logic [1:0] REG_TARGET_LEN   = 2'd2;

   localparam logic [TLEN_W-1:0] TLEN_RESET = 25'h100_0000;

   localparam logic [BYTE_W-1:0] ASCII_P = 8'h50;
   localparam logic [BYTE_W-1:0] ASCII_A = 8'h41;
   localparam logic [BYTE_W-1:0] ASCII_T = 8'h54;
   localparam logic [BYTE_W-1:0] ASCII_C = 8'h43;
   localparam logic [BYTE_W-1:0] ASCII_H = 8'h48;
   localparam logic [BYTE_W-1:0] ASCII_E = 8'h45;
   localparam logic [BYTE_W-1:0] ASCII_O = 8'h4F;
   localparam logic [BYTE_W-1:0] ASCII_F = 8'h46;
   localparam logic [ADDR_W-1:0] EOF_MARK = {ASCII_E, ASCII_O, ASCII_F};
   localparam logic [2:0] HEADER_LEN = 3'd5;

   typedef struct packed {
      logic              check_header;
      logic              check_end_marker;
      logic [TLEN_W-1:0] target_length;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [ADDR_W-1:0] write_address;
      logic [LEN_W-1:0]  run_length;
      logic [BYTE_W-1:0] fill_value;
      logic              final_result;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

   function automatic logic [BYTE_W-1:0] magic_byte(input logic [2:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         3'd0: b = ASCII_P;
         3'd1: b = ASCII_A;
         3'd2: b = ASCII_T;
         3'd3: b = ASCII_C;
         3'd4: b = ASCII_H;
         default: b = '0;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/ips_chan_if.sv
// Valid/ready channel interfaces for patch bytes and result words.
interface ips_req_if import ips_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] patch_byte;
   logic              stream_last;

   modport source (output valid, patch_byte, stream_last, input ready);
   modport sink   (input valid, patch_byte, stream_last, output ready);
endinterface

interface ips_rsp_if import ips_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [ADDR_W-1:0] write_address;
   logic [LEN_W-1:0]  run_length;
   logic [BYTE_W-1:0] fill_value;
   logic              final_result;

   modport source (output valid, result_kind, write_address, run_length, fill_value,
                   final_result, input ready);
   modport sink   (input valid, result_kind, write_address, run_length, fill_value,
                   final_result, output ready);
endinterface

>>> rtl/ips_csr_regs.sv
// APB-style configuration registers of the IPS patch stream applier.
module ips_csr_regs import ips_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic              chk_hdr_ff, chk_hdr_in;
   logic              chk_end_ff, chk_end_in;
   logic [TLEN_W-1:0] tlen_ff, tlen_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];

   always_comb begin
      chk_hdr_in = chk_hdr_ff;
      chk_end_in = chk_end_ff;
      tlen_in    = tlen_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CHECK_HEADER: chk_hdr_in = pwdata[0];
            REG_CHECK_END:    chk_end_in = pwdata[0];
            REG_TARGET_LEN:   tlen_in    = pwdata[TLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CHECK_HEADER: prdata = {{(CSR_DW-1){1'b0}}, chk_hdr_ff};
         REG_CHECK_END:    prdata = {{(CSR_DW-1){1'b0}}, chk_end_ff};
         REG_TARGET_LEN:   prdata = {{(CSR_DW-TLEN_W){1'b0}}, tlen_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_hdr_ff <= 1'b1;
         chk_end_ff <= 1'b1;
         tlen_ff    <= TLEN_RESET;
      end else begin
         chk_hdr_ff <= chk_hdr_in;
         chk_end_ff <= chk_end_in;
         tlen_ff    <= tlen_in;
      end
   end

   assign cfg = '{check_header: chk_hdr_ff, check_end_marker: chk_end_ff,
                  target_length: tlen_ff};

endmodule

>>> rtl/ips_parser.sv
// Input register and single-pass IPS record parser producing up to two result words.
module ips_parser import ips_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ips_req_if.sink  req_chan,
   input  cfg_type  cfg,
   input  logic     room,
   output push_type push
);

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_OFFSET  = 3'd1;
   localparam logic [2:0] PH_SIZE    = 3'd2;
   localparam logic [2:0] PH_LITERAL = 3'd3;
   localparam logic [2:0] PH_COUNT   = 3'd4;
   localparam logic [2:0] PH_VALUE   = 3'd5;
   localparam logic [2:0] PH_IGNORE  = 3'd6;

   logic              in_vld_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic [2:0]        phase_ff, phase_in;
   logic [2:0]        step_ff, step_in;
   logic [ADDR_W-1:0] offset_ff, offset_in;
   logic [LEN_W-1:0]  size_ff, size_in;
   logic [ADDR_W-1:0] wptr_ff, wptr_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;

   logic              advance;
   logic              hdr_skip;
   logic [2:0]        cur_phase, cur_step, step_inc;
   logic [ADDR_W-1:0] offset_new;
   logic [LEN_W-1:0]  size_new, remain_dec;
   logic [TLEN_W-1:0] lit_end, fill_end;
   logic              wr_hit, fin_hit;
   logic [ADDR_W-1:0] wr_addr;
   logic [LEN_W-1:0]  wr_len;
   logic [KIND_W-1:0] fin_kind;
   rsp_word_type      wr_word, fin_word;

   assign advance        = in_vld_ff && room;
   assign req_chan.ready = !in_vld_ff || advance;

   assign hdr_skip   = (phase_ff == PH_HEADER) && !cfg.check_header;
   assign cur_phase  = hdr_skip ? PH_OFFSET : phase_ff;
   assign cur_step   = hdr_skip ? 3'd0 : step_ff;
   assign step_inc   = cur_step + 3'd1;
   assign offset_new = {offset_ff[ADDR_W-BYTE_W-1:0], in_byte_ff};
   assign size_new   = {size_ff[LEN_W-BYTE_W-1:0], in_byte_ff};
   assign remain_dec = remain_ff - 16'd1;
   assign lit_end    = {1'b0, offset_ff} + {{(TLEN_W-LEN_W){1'b0}}, size_new};
   assign fill_end   = {1'b0, offset_ff} + {{(TLEN_W-LEN_W){1'b0}}, size_ff};

   always_comb begin
      phase_in  = cur_phase;
      step_in   = cur_step;
      offset_in = offset_ff;
      size_in   = size_ff;
      wptr_in   = wptr_ff;
      remain_in = remain_ff;
      wr_hit    = 1'b0;
      wr_addr   = '0;
      wr_len    = '0;
      fin_hit   = 1'b0;
      fin_kind  = KIND_OK;
      unique case (cur_phase)
         PH_HEADER: begin
            if (cur_step >= HEADER_LEN || in_byte_ff != magic_byte(cur_step)) begin
               fin_hit  = 1'b1;
               fin_kind = KIND_MAGIC;
            end else if (step_inc == HEADER_LEN) begin
               phase_in = PH_OFFSET;
               step_in  = 3'd0;
               fin_hit  = in_last_ff;
               fin_kind = KIND_OK;
            end else begin
               step_in  = step_inc;
               fin_hit  = in_last_ff;
               fin_kind = KIND_TRUNC;
            end
         end
         PH_OFFSET: begin
            offset_in = offset_new;
            step_in   = step_inc;
            if (step_inc < 3'd3) begin
               fin_hit  = in_last_ff;
               fin_kind = KIND_TRUNC;
            end else if (cfg.check_end_marker && offset_new == EOF_MARK) begin
               fin_hit  = 1'b1;
               fin_kind = KIND_OK;
            end else if (in_last_ff) begin
               fin_hit  = 1'b1;
               fin_kind = KIND_TRUNC;
            end else begin
               phase_in = PH_SIZE;
               step_in  = 3'd0;
            end
         end
         PH_SIZE: begin
            size_in = size_new;
            step_in = step_inc;
            if (step_inc < 3'd2) begin
               fin_hit  = in_last_ff;
               fin_kind = KIND_TRUNC;
            end else if (lit_end > cfg.target_length || in_last_ff) begin
               fin_hit  = 1'b1;
               fin_kind = KIND_TRUNC;
            end else if (size_new != '0) begin
               phase_in  = PH_LITERAL;
               wptr_in   = offset_ff;
               remain_in = size_new;
            end else begin
               phase_in = PH_COUNT;
               step_in  = 3'd0;
            end
         end
         PH_LITERAL: begin
            wr_hit    = 1'b1;
            wr_addr   = wptr_ff;
            wr_len    = 16'd1;
            wptr_in   = wptr_ff + 24'd1;
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_OFFSET;
               step_in  = 3'd0;
               fin_hit  = in_last_ff;
               fin_kind = KIND_OK;
            end else begin
               fin_hit  = in_last_ff;
               fin_kind = KIND_TRUNC;
            end
         end
         PH_COUNT: begin
            size_in = size_new;
            step_in = step_inc;
            if (in_last_ff) begin
               fin_hit  = 1'b1;
               fin_kind = KIND_TRUNC;
            end else if (step_inc >= 3'd2) begin
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (fill_end > cfg.target_length) begin
               fin_hit  = 1'b1;
               fin_kind = KIND_TRUNC;
            end else begin
               wr_hit   = (size_ff != '0);
               wr_addr  = offset_ff;
               wr_len   = size_ff;
               phase_in = PH_OFFSET;
               step_in  = 3'd0;
               fin_hit  = in_last_ff;
               fin_kind = KIND_OK;
            end
         end
         default: ;
      endcase
      if (in_last_ff) begin
         phase_in = PH_HEADER;
         step_in  = 3'd0;
      end else if (fin_hit) begin
         phase_in = PH_IGNORE;
      end
   end

   assign wr_word  = '{result_kind: KIND_WRITE, write_address: wr_addr, run_length: wr_len,
                       fill_value: in_byte_ff, final_result: 1'b0};
   assign fin_word = '{result_kind: fin_kind, write_address: '0, run_length: '0,
                       fill_value: '0, final_result: 1'b1};

   assign push.first  = wr_hit ? wr_word : fin_word;
   assign push.second = fin_word;
   assign push.count  = advance ? ({1'b0, wr_hit} + {1'b0, fin_hit}) : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         phase_ff  <= PH_HEADER;
         step_ff   <= 3'd0;
      end else begin
         if (req_chan.ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (advance) begin
            phase_ff <= phase_in;
            step_ff  <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.patch_byte;
         in_last_ff <= req_chan.stream_last;
      end
      if (advance) begin
         offset_ff <= offset_in;
         size_ff   <= size_in;
         wptr_ff   <= wptr_in;
         remain_ff <= remain_in;
      end
   end

endmodule

>>> rtl/ips_rsp_fifo.sv
// Result word queue taking up to two words a cycle and handing out one.
module ips_rsp_fifo import ips_pkg::*; #(
   parameter int DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      room,
   ips_rsp_if.source rsp_chan
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_word_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_p1, wr_ptr_p2;
   logic             pop;
   rsp_word_type     head;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_ptr_p1 = ptr_next(wr_ptr_ff);
   assign wr_ptr_p2 = ptr_next(wr_ptr_p1);
   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_p1;
         2'd2:    wr_ptr_in = wr_ptr_p2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_p1] <= push.second;
      end
   end

   assign head                   = mem_ff[rd_ptr_ff];
   assign rsp_chan.valid         = (count_ff != '0);
   assign rsp_chan.result_kind   = head.result_kind;
   assign rsp_chan.write_address = head.write_address;
   assign rsp_chan.run_length    = head.run_length;
   assign rsp_chan.fill_value    = head.fill_value;
   assign rsp_chan.final_result  = head.final_result;

endmodule

>>> rtl/ips_patch_stream_applier.sv
// Top level of the IPS patch stream applier: registers, parser and result queue.
//
//   channel   direction  handshake            word
//   req_chan  in         valid/ready          patch_byte, stream_last
//   rsp_chan  out        valid/ready          result_kind .. final_result
//   APB       in/out     psel/penable/pready  32-bit registers at 4*index
//
// One patch byte is taken per cycle while the result queue has room; its result words pass
// through the input register and then the result queue before they are offered.
// A byte that gives two words (a write followed by the end status) puts both into
// the result queue of RSP_DEPTH words, which hands them out one at a time.
// Reset clears the parser, the queue and restores the registers to defaults.
// Input stalls when the queue has fewer than two free slots.
module ips_patch_stream_applier import ips_pkg::*; #(
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   ips_req_if.sink           req_chan,
   ips_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type  cfg;
   push_type push;
   logic     room;

   ips_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ips_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg),
      .room     (room),
      .push     (push)
   );

   ips_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/ips_checker.sv
// Port-level checker of the IPS patch stream applier and its bind.
`include "ips_patch_stream_applier_macros.svh"

module ips_checker import ips_pkg::*; (
   input logic       clock,
   input logic       reset,
   ips_rsp_if.source rsp_chan
);

   localparam int RSP_BITS = KIND_W + ADDR_W + LEN_W + BYTE_W + 1;

   logic                rsp_stall;
   logic                rsp_final_ok;
   logic                rsp_status;
   logic                rsp_write;
   logic                rsp_zero;
   logic [RSP_BITS-1:0] rsp_bits;

   assign rsp_stall    = rsp_chan.valid && !rsp_chan.ready;
   assign rsp_final_ok = rsp_chan.final_result == (rsp_chan.result_kind != KIND_WRITE);
   assign rsp_status   = rsp_chan.valid && (rsp_chan.result_kind != KIND_WRITE);
   assign rsp_write    = rsp_chan.valid && (rsp_chan.result_kind == KIND_WRITE);
   assign rsp_zero     = (rsp_chan.write_address == '0) && (rsp_chan.run_length == '0)
                         && (rsp_chan.fill_value == '0);
   assign rsp_bits     = {rsp_chan.result_kind, rsp_chan.write_address, rsp_chan.run_length,
                          rsp_chan.fill_value, rsp_chan.final_result};

   `IPS_ASSERT_AFTER(a_empty_after_reset, clock, reset, !rsp_chan.valid)
   `IPS_ASSERT_HOLD(a_stall_hold, clock, reset, rsp_stall, rsp_chan.valid && $stable(rsp_bits))
   `IPS_ASSERT_IMPLY(a_final_on_status, clock, reset, rsp_chan.valid, rsp_final_ok)
   `IPS_ASSERT_IMPLY(a_status_zero, clock, reset, rsp_status, rsp_zero)
   `IPS_ASSERT_IMPLY(a_write_len, clock, reset, rsp_write, rsp_chan.run_length != '0)

endmodule

bind ips_patch_stream_applier ips_checker u_ips_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_chan (rsp_chan)
);

>>> sim/tb.sv
// Testbench for the IPS patch stream applier: byte driver, result monitor and parser predictor.
`timescale 1ns / 100ps

module tb;
   import ips_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam logic [39:0] MAGIC_CHARS = {ASCII_P, ASCII_A, ASCII_T, ASCII_C, ASCII_H};

   typedef enum logic [2:0] {
      STAGE_HEADER, STAGE_OFFSET, STAGE_SIZE, STAGE_LITERAL, STAGE_COUNT, STAGE_VALUE,
      STAGE_IGNORE
   } stage_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } patch_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   ips_req_if req_chan ();
   ips_rsp_if rsp_chan ();

   ips_patch_stream_applier i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   // parser mirror and its register copy
   cfg_type           cfg = '{1'b1, 1'b1, TLEN_RESET};
   stage_type         stage = STAGE_HEADER;
   int                step = 0;
   logic [ADDR_W-1:0] rec_offset = '0;
   logic [LEN_W-1:0]  rec_size = '0;
   logic [ADDR_W-1:0] wr_ptr = '0;
   logic [LEN_W-1:0]  bytes_left = '0;

   rsp_word_type   expected_words [$];
   patch_item_type pending_bytes [$];
   int             mismatches = 0;
   int             cycle_count = 0;

   patch_item_type req_item = '0;
   logic           req_busy = 1'b0;
   int             req_gap = 0;
   logic           req_idle_on = 1'b1;
   logic           byte_taken = 1'b0;

   int   rsp_gap = 0;
   logic rsp_idle_on = 1'b1;
   logic word_taken = 1'b0;
   int   hold_asks = 0;
   int   hold_seen = 0;
   int   hold_left = 0;

   task automatic push_word(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                            input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] val,
                            input logic fin);
      rsp_word_type w;
      w.result_kind = kind;
      w.write_address = addr;
      w.run_length = len;
      w.fill_value = val;
      w.final_result = fin;
      expected_words.push_back(w);
   endtask

   task automatic restart_parser();
      stage = STAGE_HEADER;
      step = 0;
      rec_offset = '0;
      rec_size = '0;
      wr_ptr = '0;
      bytes_left = '0;
   endtask

   task automatic close_patch(input logic [KIND_W-1:0] kind, input logic last);
      push_word(kind, '0, '0, '0, 1'b1);
      if (last) begin
         restart_parser();
      end else begin
         stage = STAGE_IGNORE;
      end
   endtask

   function automatic logic record_overruns();
      return ({2'b00, rec_offset} + {10'd0, rec_size}) > {1'b0, cfg.target_length};
   endfunction

   task automatic apply_patch_byte(input logic [BYTE_W-1:0] b, input logic last);
      if (stage == STAGE_HEADER && !cfg.check_header) begin
         stage = STAGE_OFFSET;
         step = 0;
      end
      case (stage)
         STAGE_HEADER: begin
            if (b != MAGIC_CHARS[39 - 8*step -: 8]) begin
               close_patch(KIND_MAGIC, last);
            end else begin
               step++;
               if (step == HEADER_LEN) begin
                  stage = STAGE_OFFSET;
                  step = 0;
                  if (last) close_patch(KIND_OK, last);
               end else if (last) begin
                  close_patch(KIND_TRUNC, last);
               end
            end
         end
         STAGE_OFFSET: begin
            rec_offset = {rec_offset[15:0], b};
            step++;
            if (step < 3) begin
               if (last) close_patch(KIND_TRUNC, last);
            end else if (cfg.check_end_marker && rec_offset == EOF_MARK) begin
               close_patch(KIND_OK, last);
            end else if (last) begin
               close_patch(KIND_TRUNC, last);
            end else begin
               stage = STAGE_SIZE;
               step = 0;
            end
         end
         STAGE_SIZE: begin
            rec_size = {rec_size[7:0], b};
            step++;
            if (step < 2) begin
               if (last) close_patch(KIND_TRUNC, last);
            end else if (record_overruns() || last) begin
               close_patch(KIND_TRUNC, last);
            end else if (rec_size != 0) begin
               stage = STAGE_LITERAL;
               wr_ptr = rec_offset;
               bytes_left = rec_size;
            end else begin
               stage = STAGE_COUNT;
               step = 0;
            end
         end
         STAGE_LITERAL: begin
            push_word(KIND_WRITE, wr_ptr, 16'd1, b, 1'b0);
            wr_ptr = wr_ptr + 1'b1;
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) begin
               stage = STAGE_OFFSET;
               step = 0;
               if (last) close_patch(KIND_OK, last);
            end else if (last) begin
               close_patch(KIND_TRUNC, last);
            end
         end
         STAGE_COUNT: begin
            rec_size = {rec_size[7:0], b};
            step++;
            if (last) begin
               close_patch(KIND_TRUNC, last);
            end else if (step >= 2) begin
               stage = STAGE_VALUE;
            end
         end
         STAGE_VALUE: begin
            if (record_overruns()) begin
               close_patch(KIND_TRUNC, last);
            end else begin
               if (rec_size != 0) push_word(KIND_WRITE, rec_offset, rec_size, b, 1'b0);
               stage = STAGE_OFFSET;
               step = 0;
               if (last) close_patch(KIND_OK, last);
            end
         end
         default: begin
            if (last) restart_parser();
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // monitor: predict on accepted bytes, compare accepted words
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      byte_taken <= !reset && req_chan.valid && req_chan.ready;
      word_taken <= !reset && rsp_chan.valid && rsp_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         apply_patch_byte(req_chan.patch_byte, req_chan.stream_last);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.result_kind = rsp_chan.result_kind;
         got.write_address = rsp_chan.write_address;
         got.run_length = rsp_chan.run_length;
         got.fill_value = rsp_chan.fill_value;
         got.final_result = rsp_chan.final_result;
         if (expected_words.size() == 0) begin
            $error("unexpected result word: kind %0d, address 0x%0h", got.result_kind,
                   got.write_address);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            check_field("result_kind", ADDR_W'(want.result_kind), ADDR_W'(got.result_kind));
            check_field("write_address", want.write_address, got.write_address);
            check_field("run_length", ADDR_W'(want.run_length), ADDR_W'(got.run_length));
            check_field("fill_value", ADDR_W'(want.fill_value), ADDR_W'(got.fill_value));
            check_field("final_result", ADDR_W'(want.final_result),
                        ADDR_W'(got.final_result));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // byte driver
   always @(negedge clock) begin
      if (byte_taken) begin
         req_busy = 1'b0;
         req_gap = req_idle_on ? $urandom_range(0, 3) : 0;
         if ($urandom_range(0, 39) == 0) req_idle_on = !req_idle_on;
      end
      if (!reset && !req_busy && pending_bytes.size() != 0) begin
         if (req_gap != 0) begin
            req_gap--;
         end else begin
            req_item = pending_bytes.pop_front();
            req_busy = 1'b1;
         end
      end
      req_chan.valid <= req_busy;
      req_chan.patch_byte <= req_item.data;
      req_chan.stream_last <= req_item.last;
   end

   // result receiver
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (word_taken) begin
         rsp_gap = rsp_idle_on ? $urandom_range(0, 3) : 0;
         if ($urandom_range(0, 39) == 0) rsp_idle_on = !rsp_idle_on;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
      end
      if (hold_left != 0) hold_left--;
      rsp_chan.ready <= (rsp_gap == 0) && (hold_left == 0);
   end

   task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last);
      patch_item_type item;
      item.data = b;
      item.last = last;
      pending_bytes.push_back(item);
   endtask

   function automatic int unsigned pick_offset(input int unsigned len);
      int unsigned tgt;
      int unsigned top;
      int unsigned r;
      tgt = 32'(cfg.target_length);
      if (tgt < len) return $urandom_range(0, 24'hFF_FFFF);
      top = tgt - len;
      if (top > 24'hFF_FFFF) top = 24'hFF_FFFF;
      r = $urandom_range(0, 9);
      if (r <= 5) return $urandom_range(0, top);
      if (r == 6) return top;
      if (r == 7) return (top < 24'hFF_FFFF) ? top + 1 : top;
      if (r == 8) return 24'hFF_FFFF - $urandom_range(0, 3);
      return $urandom_range(0, 24'hFF_FFFF);
   endfunction

   // one patch stream, mostly well formed, sometimes cut short or corrupted
   task automatic queue_random_patch(output int added);
      logic [BYTE_W-1:0] body [$];
      logic [ADDR_W-1:0] off;
      logic [LEN_W-1:0]  cnt;
      int n_rec;
      int len;
      int pick;
      int cut;
      if (cfg.check_header) begin
         for (int i = 0; i < HEADER_LEN; i++) body.push_back(MAGIC_CHARS[39 - 8*i -: 8]);
      end
      n_rec = $urandom_range(1, 4);
      for (int r = 0; r < n_rec; r++) begin
         if ($urandom_range(0, 1) == 0) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            off = ADDR_W'(pick_offset(len));
            body.push_back(off[23:16]);
            body.push_back(off[15:8]);
            body.push_back(off[7:0]);
            body.push_back(8'h00);
            body.push_back(BYTE_W'(len));
            for (int k = 0; k < len; k++) body.push_back(BYTE_W'($urandom));
         end else begin
            pick = $urandom_range(0, 7);
            if (pick == 0) cnt = '0;
            else if (pick == 1) cnt = 16'hFFFF;
            else if (pick <= 4) cnt = LEN_W'($urandom_range(1, 64));
            else cnt = LEN_W'($urandom_range(1, 16'hFFFF));
            off = ADDR_W'(pick_offset(cnt));
            body.push_back(off[23:16]);
            body.push_back(off[15:8]);
            body.push_back(off[7:0]);
            body.push_back(8'h00);
            body.push_back(8'h00);
            body.push_back(cnt[15:8]);
            body.push_back(cnt[7:0]);
            body.push_back(BYTE_W'($urandom));
         end
      end
      if (cfg.check_end_marker && $urandom_range(0, 2) != 0) begin
         body.push_back(ASCII_E);
         body.push_back(ASCII_O);
         body.push_back(ASCII_F);
         if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 3)) body.push_back(BYTE_W'($urandom));
         end
      end
      pick = $urandom_range(0, 9);
      if (pick == 6 || pick == 7) begin
         cut = $urandom_range(0, body.size() - 1);
         while (body.size() > cut + 1) void'(body.pop_back());
      end else if (pick >= 8) begin
         body[$urandom_range(0, body.size() - 1)] = BYTE_W'($urandom);
      end
      for (int i = 0; i < body.size(); i++) queue_byte(body[i], i == body.size() - 1);
      added = body.size();
   endtask

   task automatic queue_random_bytes(input int count);
      int added;
      int total;
      total = 0;
      while (total < count) begin
         queue_random_patch(added);
         total += added;
      end
   endtask

   task automatic wait_until_drained();
      while (pending_bytes.size() != 0 || req_busy || expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_CHECK_HEADER: cfg.check_header = value[0];
         REG_CHECK_END: cfg.check_end_marker = value[0];
         REG_TARGET_LEN: cfg.target_length = value[TLEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // header, one literal, a fill ending at the top of the target, end marker, bad header
      queue_byte(ASCII_P, 1'b0); queue_byte(ASCII_A, 1'b0); queue_byte(ASCII_T, 1'b0);
      queue_byte(ASCII_C, 1'b0); queue_byte(ASCII_H, 1'b0);
      queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
      queue_byte(8'h00, 1'b0); queue_byte(8'h01, 1'b0); queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'hFE, 1'b0);
      queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
      queue_byte(8'h02, 1'b0); queue_byte(8'h00, 1'b0);
      queue_byte(ASCII_E, 1'b0); queue_byte(ASCII_O, 1'b0); queue_byte(ASCII_F, 1'b0);
      queue_byte(8'hA5, 1'b1);
      queue_byte(ASCII_P, 1'b0); queue_byte(8'h58, 1'b1);
      wait_until_drained();

      queue_random_bytes(80);
      hold_asks++;
      wait_until_drained();

      write_reg(REG_CHECK_HEADER, 32'd0);
      write_reg(REG_CHECK_END, 32'd0);
      write_reg(REG_TARGET_LEN, 32'd0);
      queue_random_bytes(60);
      wait_until_drained();

      write_reg(REG_CHECK_HEADER, 32'd1);
      write_reg(REG_TARGET_LEN, 32'h01FF_FFFF);
      queue_random_bytes(70);
      wait_until_drained();

      write_reg(REG_CHECK_HEADER, 32'd0);
      write_reg(REG_CHECK_END, 32'd1);
      write_reg(REG_TARGET_LEN, $urandom_range(1, 400));
      queue_random_bytes(70);
      hold_asks++;
      wait_until_drained();

      write_reg(REG_CHECK_HEADER, $urandom_range(0, 1));
      write_reg(REG_CHECK_END, $urandom_range(0, 1));
      write_reg(REG_TARGET_LEN, $urandom_range(0, 32'h01FF_FFFF));
      queue_random_bytes(80);
      wait_until_drained();

      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
